>>> hdl/assert_macros.svh
// Assertion macros for the futex wait table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, ignored while in reset.
`define FWT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("futex wait table: assertion failed");

// Next-cycle implication, ignored while in reset.
`define FWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("futex wait table: assertion failed");

`else

`define FWT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hdl/fwt_pkg.sv
// Types, constants and field layout of the futex wait table.
package fwt_pkg;

    // Parameter defaults
    localparam int WAITER_SLOTS_DEF = 64;
    localparam int KEY_BITS_DEF     = 48;
    localparam int TASK_BITS_DEF    = 8;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 48;
    localparam int TASK_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    // Input tdata layout
    localparam int KEY_LSB   = 0;
    localparam int TASK_LSB  = KEY_LSB + KEY_W;
    localparam int SEEN_LSB  = TASK_LSB + TASK_W;
    localparam int EXP_LSB   = SEEN_LSB + VALUE_W;
    localparam int COUNT_LSB = EXP_LSB + VALUE_W;
    localparam int SLOT_LSB  = COUNT_LSB + COUNT_W;
    localparam int INTR_BIT  = SLOT_LSB + SLOT_W;
    localparam int TMO_BIT   = INTR_BIT + 1;
    localparam int S_TDATA_W = TMO_BIT + 1;

    // Output tdata layout
    localparam int ST_LSB    = 0;
    localparam int OSLOT_LSB = ST_LSB + STATUS_W;
    localparam int OTASK_LSB = OSLOT_LSB + SLOT_W;
    localparam int TOTAL_LSB = OTASK_LSB + TASK_W;
    localparam int M_TDATA_W = TOTAL_LSB + TOTAL_W;

    typedef enum logic [OP_W-1:0] {
        OP_WAIT   = 2'd0,
        OP_WAKE   = 2'd1,
        OP_FINISH = 2'd2,
        OP_EXIT   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ALIGN    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_FULL     = 3'd3,
        ST_INTR     = 3'd4,
        ST_TIMEOUT  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EMIT_PLAIN = 2'd0,
        EMIT_SLOT  = 2'd1,
        EMIT_WOKEN = 2'd2
    } emit_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       start;      // idle: point the slot index at the next op's first slot
        logic       load;       // latch the accepted transaction
        logic       idx_inc;    // advance to the next slot
        logic       mem_alloc;  // write a fresh waiter entry at the current slot
        logic       mem_woken;  // mark the current slot woken
        logic       valid_set;
        logic       valid_clr;
        logic       pend_load;  // hold the current slot as the pending wake result
        logic       emit;       // load the output register
        emit_kind_t emit_kind;
        status_t    emit_status;
        logic       emit_last;
    } fwt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  in_op;
        logic in_bad_align;
        logic in_mismatch;
        logic slot_free;
        logic idx_last;
        logic wake_match;
        logic count_hit;
        logic pend_valid;
        logic out_free;
        logic exit_match;
        logic fin_ok;
        logic slot_woken;
        logic intr;
        logic tmo;
    } fwt_stat_t;

endpackage

>>> hdl/fwt_datapath.sv
// Slot table, scan index, pending wake result and output register.
module fwt_datapath #(
    parameter int WAITER_SLOTS = fwt_pkg::WAITER_SLOTS_DEF,
    parameter int KEY_BITS     = fwt_pkg::KEY_BITS_DEF,
    parameter int TASK_BITS    = fwt_pkg::TASK_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fwt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [fwt_pkg::OP_W-1:0]       s_tuser,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [fwt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  fwt_pkg::fwt_cmd_t              cmd,
    output fwt_pkg::fwt_stat_t             stat
);

    localparam int IDX_W   = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int ENTRY_W = 1 + TASK_BITS + KEY_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WAITER_SLOTS - 1);
    localparam logic [fwt_pkg::SLOT_W:0] SLOTS_EXT = (fwt_pkg::SLOT_W + 1)'(WAITER_SLOTS);

    // Unpacked input fields
    logic [fwt_pkg::KEY_W-1:0]   in_key;
    logic [fwt_pkg::TASK_W-1:0]  in_task;
    logic [fwt_pkg::VALUE_W-1:0] in_seen;
    logic [fwt_pkg::VALUE_W-1:0] in_exp;
    logic [fwt_pkg::COUNT_W-1:0] in_count;
    logic [fwt_pkg::SLOT_W-1:0]  in_slot;
    fwt_pkg::op_t                in_op;
    logic [IDX_W-1:0]            start_idx;

    // Latched operation
    logic [KEY_BITS-1:0]         key_reg;
    logic [TASK_BITS-1:0]        task_reg;
    logic [fwt_pkg::COUNT_W-1:0] count_reg;
    logic                        intr_reg;
    logic                        tmo_reg;
    logic                        range_reg;

    // Scan state
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic [fwt_pkg::TOTAL_W-1:0] n_reg;
    logic                        pend_valid_reg;
    logic [TASK_BITS-1:0]        pend_task_reg;
    logic [fwt_pkg::TOTAL_W-1:0] pend_total_reg;
    logic [WAITER_SLOTS-1:0]     valid_reg;

    // Slot memory: {woken, task, key}
    logic [ENTRY_W-1:0]          mem [WAITER_SLOTS];
    logic [ENTRY_W-1:0]          rd_reg;
    logic [ENTRY_W-1:0]          wr_data;
    logic [KEY_BITS-1:0]         rd_key;
    logic [TASK_BITS-1:0]        rd_task;
    logic                        rd_woken;
    logic                        cur_valid;

    // Output register
    logic                          m_tvalid_reg;
    logic [fwt_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [fwt_pkg::M_TDATA_W-1:0] m_tdata_next;
    logic                          m_tuser_reg;
    logic                          m_tuser_next;
    logic                          m_tlast_reg;

    assign in_key   = s_tdata[fwt_pkg::KEY_LSB +: fwt_pkg::KEY_W];
    assign in_task  = s_tdata[fwt_pkg::TASK_LSB +: fwt_pkg::TASK_W];
    assign in_seen  = s_tdata[fwt_pkg::SEEN_LSB +: fwt_pkg::VALUE_W];
    assign in_exp   = s_tdata[fwt_pkg::EXP_LSB +: fwt_pkg::VALUE_W];
    assign in_count = s_tdata[fwt_pkg::COUNT_LSB +: fwt_pkg::COUNT_W];
    assign in_slot  = s_tdata[fwt_pkg::SLOT_LSB +: fwt_pkg::SLOT_W];
    assign in_op    = fwt_pkg::op_t'(s_tuser);

    // Finish starts at its own slot, every scan at slot zero
    assign start_idx = (in_op == fwt_pkg::OP_FINISH) ? IDX_W'(in_slot) : '0;

    always_comb
    begin
        if (cmd.start)
        begin
            idx_next = start_idx;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign rd_key    = rd_reg[KEY_BITS-1:0];
    assign rd_task   = rd_reg[KEY_BITS +: TASK_BITS];
    assign rd_woken  = rd_reg[ENTRY_W-1];
    assign cur_valid = valid_reg[idx_reg];

    assign wr_data = cmd.mem_alloc ? {1'b0, task_reg, key_reg} : {1'b1, rd_task, key_reg};

    // Read the slot of the next cycle; write the current one
    always_ff @(posedge clk)
    begin
        if (cmd.mem_alloc || cmd.mem_woken)
        begin
            mem[idx_reg] <= wr_data;
        end
        rd_reg <= mem[idx_next];
    end

    // Latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= KEY_BITS'(in_key);
            task_reg  <= TASK_BITS'(in_task);
            count_reg <= (in_count == '0) ? fwt_pkg::COUNT_W'(1) : in_count;
            intr_reg  <= s_tdata[fwt_pkg::INTR_BIT];
            tmo_reg   <= s_tdata[fwt_pkg::TMO_BIT];
            range_reg <= ({1'b0, in_slot} < SLOTS_EXT);
        end
        if (cmd.pend_load)
        begin
            pend_task_reg  <= rd_task;
            pend_total_reg <= n_reg + fwt_pkg::TOTAL_W'(1);
        end
    end

    // Scan control state and slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_load)
            begin
                n_reg          <= n_reg + fwt_pkg::TOTAL_W'(1);
                pend_valid_reg <= 1'b1;
            end
            if (cmd.valid_set)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            else if (cmd.valid_clr)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Build the result transaction
    always_comb
    begin
        m_tdata_next = '0;
        m_tuser_next = 1'b0;
        m_tdata_next[fwt_pkg::ST_LSB +: fwt_pkg::STATUS_W] = cmd.emit_status;
        unique case (cmd.emit_kind)
            fwt_pkg::EMIT_PLAIN:
            begin
                m_tuser_next = 1'b0;
            end
            fwt_pkg::EMIT_SLOT:
            begin
                m_tdata_next[fwt_pkg::OSLOT_LSB +: fwt_pkg::SLOT_W] = fwt_pkg::SLOT_W'(idx_reg);
            end
            fwt_pkg::EMIT_WOKEN:
            begin
                m_tdata_next[fwt_pkg::OTASK_LSB +: fwt_pkg::TASK_W] =
                    fwt_pkg::TASK_W'(pend_task_reg);
                m_tdata_next[fwt_pkg::TOTAL_LSB +: fwt_pkg::TOTAL_W] = pend_total_reg;
                m_tuser_next = 1'b1;
            end
            default:
            begin
                m_tuser_next = 1'b0;
            end
        endcase
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Status to the controller
    assign stat.in_op        = in_op;
    assign stat.in_bad_align = |in_key[1:0];
    assign stat.in_mismatch  = (in_seen != in_exp);
    assign stat.slot_free    = !cur_valid;
    assign stat.idx_last     = (idx_reg == IDX_LAST);
    assign stat.wake_match   = cur_valid && (rd_key == key_reg) && !rd_woken;
    assign stat.count_hit    =
        ((fwt_pkg::COUNT_W'(n_reg) + fwt_pkg::COUNT_W'(1)) == count_reg);
    assign stat.pend_valid   = pend_valid_reg;
    assign stat.out_free     = !m_tvalid_reg || m_tready;
    assign stat.exit_match   = cur_valid && (rd_task == task_reg);
    assign stat.fin_ok       = range_reg && cur_valid;
    assign stat.slot_woken   = rd_woken;
    assign stat.intr         = intr_reg;
    assign stat.tmo          = tmo_reg;

endmodule

>>> hdl/fwt_ctrl.sv
// Operation sequencer of the futex wait table.
module fwt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fwt_pkg::fwt_stat_t  stat,
    output fwt_pkg::fwt_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_WAIT_SCAN,
        S_WAKE_SCAN,
        S_WAKE_END,
        S_FINISH,
        S_EXIT_SCAN
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    fwt_pkg::status_t  resp_status_reg;
    fwt_pkg::status_t  resp_status_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next       = state_reg;
        resp_status_next = resp_status_reg;
        cmd              = '0;
        cmd.emit_kind    = fwt_pkg::EMIT_PLAIN;
        cmd.emit_status  = fwt_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.start = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    unique case (stat.in_op)
                        fwt_pkg::OP_WAIT:
                        begin
                            priority if (stat.in_bad_align)
                            begin
                                resp_status_next = fwt_pkg::ST_ALIGN;
                                state_next       = S_RESP;
                            end
                            else if (stat.in_mismatch)
                            begin
                                resp_status_next = fwt_pkg::ST_MISMATCH;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WAIT_SCAN;
                            end
                        end
                        fwt_pkg::OP_WAKE:
                        begin
                            if (stat.in_bad_align)
                            begin
                                resp_status_next = fwt_pkg::ST_ALIGN;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WAKE_SCAN;
                            end
                        end
                        fwt_pkg::OP_FINISH:
                        begin
                            state_next = S_FINISH;
                        end
                        fwt_pkg::OP_EXIT:
                        begin
                            resp_status_next = fwt_pkg::ST_OK;
                            state_next       = S_EXIT_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = resp_status_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WAIT_SCAN:
            begin
                // Take the lowest free slot
                priority if (stat.slot_free)
                begin
                    if (stat.out_free)
                    begin
                        cmd.mem_alloc = 1'b1;
                        cmd.valid_set = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = fwt_pkg::EMIT_SLOT;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (stat.idx_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = fwt_pkg::ST_FULL;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_WAKE_SCAN:
            begin
                // Release the held result when the next waiter turns up
                if (stat.wake_match)
                begin
                    if (!stat.pend_valid || stat.out_free)
                    begin
                        cmd.emit      = stat.pend_valid;
                        cmd.emit_kind = fwt_pkg::EMIT_WOKEN;
                        cmd.mem_woken = 1'b1;
                        cmd.pend_load = 1'b1;
                        if (stat.count_hit || stat.idx_last)
                        begin
                            state_next = S_WAKE_END;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                end
                else if (stat.idx_last)
                begin
                    state_next = S_WAKE_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_WAKE_END:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = stat.pend_valid ? fwt_pkg::EMIT_WOKEN : fwt_pkg::EMIT_PLAIN;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.valid_clr = stat.fin_ok;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    priority if (stat.fin_ok && stat.slot_woken)
                    begin
                        cmd.emit_status = fwt_pkg::ST_OK;
                    end
                    else if (stat.intr)
                    begin
                        cmd.emit_status = fwt_pkg::ST_INTR;
                    end
                    else if (stat.tmo)
                    begin
                        cmd.emit_status = fwt_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        cmd.emit_status = fwt_pkg::ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            S_EXIT_SCAN:
            begin
                // Free every slot of the exiting task
                cmd.valid_clr = stat.exit_match;
                if (stat.idx_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the pending response code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            resp_status_reg <= fwt_pkg::ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
        end
    end

endmodule

>>> hdl/futex_wait_table_unit.sv
// Top level of the futex wait table: sequencer plus slot datapath.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+-----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | one operation: wait, wake, finish, exit
//  m_*      | out | m_tvalid/m_tready  | result transactions, m_tlast on the final
//
//  One operation at a time; one slot per cycle from a registered memory read, unless
//  a result finds the output register full. Reset clears the slot valid bits at once;
//  no clearing pass is run. A result that cannot enter the full output register holds
//  the scan on its slot.
`include "assert_macros.svh"

module futex_wait_table_unit #(
    parameter int WAITER_SLOTS = fwt_pkg::WAITER_SLOTS_DEF,
    parameter int KEY_BITS     = fwt_pkg::KEY_BITS_DEF,
    parameter int TASK_BITS    = fwt_pkg::TASK_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key[47:0], task_id[55:48], seen_value[87:56], expected_value[119:88],
    // wake_count[135:120], slot_index[141:136], interrupted[142], has_timeout[143]
    input  logic [fwt_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [fwt_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], slot_out[8:3], woken_task[16:9], woken_total[23:17]
    output logic [fwt_pkg::M_TDATA_W-1:0]  m_tdata,
    // woken_valid[0]
    output logic                           m_tuser,
    output logic                           m_tlast
);

    fwt_pkg::fwt_cmd_t  cmd;
    fwt_pkg::fwt_stat_t stat;

    // Result fields watched by the checks
    logic [fwt_pkg::STATUS_W-1:0] out_status;
    logic [fwt_pkg::TOTAL_W-1:0]  out_total;

    fwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fwt_datapath #(
        .WAITER_SLOTS (WAITER_SLOTS),
        .KEY_BITS     (KEY_BITS),
        .TASK_BITS    (TASK_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign out_status = m_tdata[fwt_pkg::ST_LSB +: fwt_pkg::STATUS_W];
    assign out_total  = m_tdata[fwt_pkg::TOTAL_LSB +: fwt_pkg::TOTAL_W];

    // Checks
    `FWT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `FWT_ASSERT_NEXT(a_emit_shows_valid, clk, rst_n, cmd.emit, m_tvalid)
    `FWT_ASSERT_IMP(a_total_with_task, clk, rst_n, m_tvalid, m_tuser == (out_total != '0))
    `FWT_ASSERT_IMP(a_woken_is_ok, clk, rst_n, m_tvalid && m_tuser, out_status == fwt_pkg::ST_OK)

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the futex wait table: directed and random operations on a stream bus.
module tb_top;
    import fwt_pkg::*;

    localparam int SLOTS        = WAITER_SLOTS_DEF;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int KEY_POOL_N   = 6;

    // One operation as offered on the input stream
    typedef struct {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [TASK_W-1:0] task_id;
        logic [VALUE_W-1:0] seen;
        logic [VALUE_W-1:0] expected;
        logic [COUNT_W-1:0] wake_count;
        logic [SLOT_W-1:0] slot_index;
        logic              intr;
        logic              tmo;
    } fwt_req_t;

    // One result transaction as it should leave the block
    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [TASK_W-1:0]  woken_task;
        logic               woken_valid;
        logic [TOTAL_W-1:0] woken_total;
        logic               last;
    } fwt_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    futex_wait_table_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the waiter table
    logic               waiter_live  [SLOTS];
    logic [KEY_W-1:0]   waiter_key   [SLOTS];
    logic [TASK_W-1:0]  waiter_task  [SLOTS];
    logic               waiter_woken [SLOTS];

    fwt_result_t        pending_results [$];
    fwt_result_t        result_want;
    logic [KEY_W-1:0]   key_pool [KEY_POOL_N];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int errors;
    int results_seen;
    int tasks_woken;
    int full_refusals;
    int ops_by_kind [4];
    int wait_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Build a single closing result with only the status set
    function automatic fwt_result_t final_result(input status_t st);
        fwt_result_t r;
        r.status      = st;
        r.slot        = '0;
        r.woken_task  = '0;
        r.woken_valid = 1'b0;
        r.woken_total = '0;
        r.last        = 1'b1;
        return r;
    endfunction

    // Update the shadow table for one accepted operation and queue its results
    function automatic void predict_op(input fwt_req_t r);
        fwt_result_t res;
        fwt_result_t held;
        logic        have_held;
        logic        placed;
        logic        was_woken;
        int          limit;
        int          n;
        case (r.op)
            OP_WAIT:
            begin
                if (r.key[1:0] != 2'b00)
                    pending_results.push_back(final_result(ST_ALIGN));
                else if (r.seen != r.expected)
                    pending_results.push_back(final_result(ST_MISMATCH));
                else
                begin
                    placed = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!placed && !waiter_live[i])
                        begin
                            waiter_live[i]  = 1'b1;
                            waiter_key[i]   = r.key;
                            waiter_task[i]  = r.task_id;
                            waiter_woken[i] = 1'b0;
                            res = final_result(ST_OK);
                            res.slot = SLOT_W'(i);
                            pending_results.push_back(res);
                            placed = 1'b1;
                        end
                    end
                    if (!placed)
                    begin
                        pending_results.push_back(final_result(ST_FULL));
                        full_refusals++;
                    end
                end
            end
            OP_WAKE:
            begin
                if (r.key[1:0] != 2'b00)
                    pending_results.push_back(final_result(ST_ALIGN));
                else
                begin
                    limit = (r.wake_count == '0) ? 1 : int'(r.wake_count);
                    n = 0;
                    have_held = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (n < limit && waiter_live[i] && waiter_key[i] == r.key
                            && !waiter_woken[i])
                        begin
                            waiter_woken[i] = 1'b1;
                            if (have_held)
                                pending_results.push_back(held);
                            held = final_result(ST_OK);
                            held.woken_task  = waiter_task[i];
                            held.woken_valid = 1'b1;
                            held.woken_total = TOTAL_W'(n + 1);
                            held.last        = 1'b0;
                            have_held = 1'b1;
                            n++;
                            tasks_woken++;
                        end
                    end
                    if (have_held)
                    begin
                        held.last = 1'b1;
                        pending_results.push_back(held);
                    end
                    else
                        pending_results.push_back(final_result(ST_OK));
                end
            end
            OP_FINISH:
            begin
                was_woken = 1'b0;
                if (int'(r.slot_index) < SLOTS && waiter_live[r.slot_index])
                begin
                    was_woken = waiter_woken[r.slot_index];
                    waiter_live[r.slot_index] = 1'b0;
                end
                if (was_woken)
                    pending_results.push_back(final_result(ST_OK));
                else if (r.intr)
                    pending_results.push_back(final_result(ST_INTR));
                else if (r.tmo)
                    pending_results.push_back(final_result(ST_TIMEOUT));
                else
                    pending_results.push_back(final_result(ST_OK));
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (waiter_live[i] && waiter_task[i] == r.task_id)
                        waiter_live[i] = 1'b0;
                end
                pending_results.push_back(final_result(ST_OK));
            end
        endcase
    endfunction

    // Fill every field with noise; callers override what the operation uses
    function automatic fwt_req_t random_req();
        fwt_req_t r;
        r.op         = op_t'($urandom_range(3));
        r.key        = KEY_W'({$urandom, $urandom});
        r.task_id    = TASK_W'($urandom);
        r.seen       = $urandom;
        r.expected   = $urandom;
        r.wake_count = COUNT_W'($urandom);
        r.slot_index = SLOT_W'($urandom);
        r.intr       = 1'($urandom);
        r.tmo        = 1'($urandom);
        return r;
    endfunction

    // Mostly a few busy tasks, sometimes any id
    function automatic logic [TASK_W-1:0] pick_task();
        if ($urandom_range(7) == 0)
            return TASK_W'($urandom);
        return TASK_W'($urandom_range(4));
    endfunction

    // Offer one operation and hold it until the block takes the transaction
    task automatic send_op(input fwt_req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {r.tmo, r.intr, r.slot_index, r.wake_count, r.expected, r.seen,
                    r.task_id, r.key};
        s_tuser  = r.op;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_op(r);
        ops_by_kind[r.op]++;
    endtask

    task automatic do_wait(input logic [KEY_W-1:0] key, input logic [TASK_W-1:0] task_id,
                           input logic [VALUE_W-1:0] seen, input logic [VALUE_W-1:0] expected);
        fwt_req_t r;
        r = random_req();
        r.op       = OP_WAIT;
        r.key      = key;
        r.task_id  = task_id;
        r.seen     = seen;
        r.expected = expected;
        send_op(r);
    endtask

    task automatic do_wake(input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] count);
        fwt_req_t r;
        r = random_req();
        r.op         = OP_WAKE;
        r.key        = key;
        r.wake_count = count;
        send_op(r);
    endtask

    task automatic do_finish(input logic [SLOT_W-1:0] slot, input logic intr, input logic tmo);
        fwt_req_t r;
        r = random_req();
        r.op         = OP_FINISH;
        r.slot_index = slot;
        r.intr       = intr;
        r.tmo        = tmo;
        send_op(r);
    endtask

    task automatic do_exit(input logic [TASK_W-1:0] task_id);
        fwt_req_t r;
        r = random_req();
        r.op      = OP_EXIT;
        r.task_id = task_id;
        send_op(r);
    endtask

    // Alignment and value checks, then the lowest free slot, at extreme keys
    task automatic test_wait_checks();
        do_wait(48'h0000_0000_0001, 8'd1, 32'd7, 32'd7);
        do_wait(48'h0000_0000_0002, 8'd1, 32'd7, 32'd7);
        do_wait(48'hFFFF_FFFF_FFFF, 8'd1, 32'd7, 32'd7);
        do_wait(48'h0000_0000_0010, 8'd2, 32'h0000_0000, 32'hFFFF_FFFF);
        do_wait(48'h0000_0000_0000, 8'd0, 32'h0000_0000, 32'h0000_0000);
        do_wait(48'hFFFF_FFFF_FFFC, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Misaligned wake, wake with no waiter, count zero, partial and bulk wakes
    task automatic test_wake_cases();
        do_wake(48'h0000_0000_0003, 16'd1);
        do_wake(48'h0000_0000_0100, 16'd5);
        do_wake(48'h0000_0000_0000, 16'd0);
        do_wake(48'h0000_0000_0000, 16'd1);
        do_wait(48'hFFFF_FFFF_FFFC, 8'd3, 32'd9, 32'd9);
        do_wait(48'hFFFF_FFFF_FFFC, 8'd4, 32'd9, 32'd9);
        do_wake(48'hFFFF_FFFF_FFFC, 16'd1);
        do_wake(48'hFFFF_FFFF_FFFC, 16'hFFFF);
    endtask

    // Finish on woken, unwoken and unused slots with each flag combination
    task automatic test_finish_cases();
        do_wait(48'h0000_0000_0040, 8'd5, 32'd1, 32'd1);
        do_finish(6'd0, 1'b1, 1'b1);
        do_finish(6'd0, 1'b1, 1'b0);
        do_finish(6'd63, 1'b0, 1'b1);
        do_finish(6'd62, 1'b0, 1'b0);
        do_finish(6'd4, 1'b1, 1'b1);
        do_wait(48'h0000_0000_0044, 8'd6, 32'd2, 32'd2);
        do_finish(6'd0, 1'b0, 1'b1);
    endtask

    // Exit frees every slot of one task; exit of an idle task does nothing
    task automatic test_exit_cases();
        do_exit(8'hFF);
        do_exit(8'd200);
    endtask

    // Fill all slots on one key, refuse one more, then wake every waiter at once
    task automatic test_full_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (waiter_live[i])
                do_finish(SLOT_W'(i), 1'($urandom), 1'($urandom));
        end
        for (int k = 0; k < SLOTS; k++)
            do_wait(key_pool[2], TASK_W'(k % 4), 32'h1234_5678, 32'h1234_5678);
        do_wait(key_pool[3], 8'd1, 32'd0, 32'd0);
        do_wake(key_pool[2], 16'hFFFF);
        for (int k = 0; k < 4; k++)
            do_exit(TASK_W'(k));
    endtask

    // Stall the receiver for a long stretch while operations keep coming
    task automatic test_output_backpressure();
        for (int k = 0; k < 4; k++)
            do_wait(key_pool[4], pick_task(), 32'd3, 32'd3);
        hold_left = 400;
        do_wake(key_pool[4], 16'hFFFF);
        do_wait(key_pool[5], pick_task(), 32'd4, 32'd4);
        do_wake(key_pool[5], 16'd0);
        do_exit(pick_task());
        for (int i = 0; i < SLOTS; i++)
        begin
            if (waiter_live[i])
                do_finish(SLOT_W'(i), 1'b0, 1'b0);
        end
    endtask

    // Mostly well-formed traffic on a few keys and tasks, with some noise
    task automatic test_random_traffic(input int count);
        fwt_req_t r;
        int       roll;
        int       live_q [$];
        for (int n = 0; n < count; n++)
        begin
            r = random_req();
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                // keep the fully random transaction
            end
            else if (roll < 48)
            begin
                r.op      = OP_WAIT;
                r.key     = key_pool[$urandom_range(KEY_POOL_N - 1)];
                r.task_id = pick_task();
                if ($urandom_range(9) != 0)
                    r.expected = r.seen;
            end
            else if (roll < 70)
            begin
                r.op  = OP_WAKE;
                r.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
                case ($urandom_range(3))
                    0: r.wake_count = '0;
                    1: r.wake_count = COUNT_W'($urandom_range(3));
                    2: r.wake_count = COUNT_W'($urandom);
                    default: r.wake_count = '1;
                endcase
            end
            else if (roll < 94)
            begin
                r.op = OP_FINISH;
                live_q.delete();
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (waiter_live[i])
                        live_q.push_back(i);
                end
                if (live_q.size() != 0 && $urandom_range(4) != 0)
                    r.slot_index = SLOT_W'(live_q[$urandom_range(live_q.size() - 1)]);
            end
            else
            begin
                r.op      = OP_EXIT;
                r.task_id = pick_task();
            end
            send_op(r);
        end
    endtask

    // Drive the receiver ready, honoring any long hold-off first
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                result_want = pending_results.pop_front();
                if (m_tdata[ST_LSB +: STATUS_W] != result_want.status)
                begin
                    $error("status: expected %0d, actual %0d", result_want.status,
                           m_tdata[ST_LSB +: STATUS_W]);
                    errors++;
                end
                if (m_tdata[OSLOT_LSB +: SLOT_W] != result_want.slot)
                begin
                    $error("slot_out: expected %0d, actual %0d", result_want.slot,
                           m_tdata[OSLOT_LSB +: SLOT_W]);
                    errors++;
                end
                if (m_tdata[OTASK_LSB +: TASK_W] != result_want.woken_task)
                begin
                    $error("woken_task: expected %0d, actual %0d", result_want.woken_task,
                           m_tdata[OTASK_LSB +: TASK_W]);
                    errors++;
                end
                if (m_tuser != result_want.woken_valid)
                begin
                    $error("woken_valid: expected %0d, actual %0d", result_want.woken_valid,
                           m_tuser);
                    errors++;
                end
                if (m_tdata[TOTAL_LSB +: TOTAL_W] != result_want.woken_total)
                begin
                    $error("woken_total: expected %0d, actual %0d", result_want.woken_total,
                           m_tdata[TOTAL_LSB +: TOTAL_W]);
                    errors++;
                end
                if (m_tlast != result_want.last)
                begin
                    $error("last: expected %0d, actual %0d", result_want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #8000000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        hold_left     = 0;
        errors        = 0;
        results_seen  = 0;
        tasks_woken   = 0;
        full_refusals = 0;
        for (int k = 0; k < 4; k++)
            ops_by_kind[k] = 0;
        for (int i = 0; i < SLOTS; i++)
            waiter_live[i] = 1'b0;

        // Keys shared by the structured traffic, extremes first
        key_pool[0] = '0;
        key_pool[1] = 48'hFFFF_FFFF_FFFC;
        for (int k = 2; k < KEY_POOL_N; k++)
            key_pool[k] = KEY_W'({$urandom, $urandom}) & ~KEY_W'(3);

        send_idle_pct = 21;
        recv_idle_pct = 53;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wait_checks();
        test_wake_cases();
        test_finish_cases();
        test_exit_cases();
        test_full_table();
        test_output_backpressure();
        test_random_traffic(120);

        send_idle_pct = 53;
        recv_idle_pct = 21;
        test_random_traffic(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120);

        // Withdraw the last offer, then drain
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result transactions never arrived", pending_results.size());
            errors++;
        end

        $display("Covered %0d operations: %0d wait, %0d wake, %0d finish, %0d exit.",
                 ops_by_kind[0] + ops_by_kind[1] + ops_by_kind[2] + ops_by_kind[3],
                 ops_by_kind[0], ops_by_kind[1], ops_by_kind[2], ops_by_kind[3]);
        $display("Checked %0d result transactions, %0d tasks woken, %0d full-table refusals.",
                 results_seen, tasks_woken, full_refusals);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/fwt_pkg.sv
hdl/fwt_datapath.sv
hdl/fwt_ctrl.sv
hdl/futex_wait_table_unit.sv
dv/tb_top.sv
